// ----- sv/tal_pkg.sv -----
// Package: types, op codes and sizes for the binary lifting ancestor engine.
`default_nettype none
package tal_pkg;
	localparam int MaxNodes = 1024;
	localparam int LogLevels = 10;
	localparam int NodeW = 10;
	localparam int CountW = 11;
	localparam int DistW = 11;

	typedef enum logic [2:0] {
		OP_LOAD = 3'd0,
		OP_BUILD = 3'd1,
		OP_KTH = 3'd2,
		OP_LCA = 3'd3,
		OP_DIST = 3'd4
	} op_t;

	typedef enum logic [1:0] {
		ST_OK = 2'd0,
		ST_NONE = 2'd1,
		ST_RANGE = 2'd2
	} status_t;

	typedef struct packed {
		logic [2:0] op;
		logic [NodeW-1:0] node_a;
		logic [NodeW-1:0] node_b;
		logic [NodeW-1:0] parent_node;
		logic has_parent;
		logic [CountW-1:0] node_depth;
		logic [NodeW-1:0] step_count;
	} req_t;

	typedef struct packed {
		logic [NodeW-1:0] result_node;
		logic [DistW-1:0] distance;
		logic [1:0] status;
	} rsp_t;

	typedef enum logic [4:0] {
		S_IDLE,
		S_BLD_RD0,
		S_BLD_RD1,
		S_BLD_WR,
		S_DEP_RD,
		S_DEP_WAIT,
		S_DEP_ORD,
		S_CLB_RD,
		S_CLB_USE,
		S_CMP_RDA,
		S_CMP_RDB,
		S_CMP_USE,
		S_FIN_RDA,
		S_FIN_RDB,
		S_FIN_USE,
		S_DONE
	} state_t;
endpackage
`default_nettype wire

// ----- sv/tree_ancestor_lca_engine_unit.sv -----
// Top level: binary lifting ancestor engine with table memory and sequencer.
//
// One request at a time: busy rises in the cycle after the accepting edge and
// stays high through the done cycle, which carries the one response; the next
// request can be taken in the cycle after done. Ancestor entries live in the
// single-port ancestor table, one read or write a cycle, and depths in a
// separate depth table. A load, an unused op, a bad index or a step count with
// a bit above the top level goes straight to done; a k-th ancestor query climbs
// once per set bit of step_count and stops early when it runs past a root; a
// common ancestor or distance query reads both depths, climbs the deeper node
// by their difference and, unless it lands on the other node, runs a top-down
// search and a final parent check; a build fills every level above 0 for each
// live node. The receiver cannot stall the response.
`default_nettype none
module tree_ancestor_lca_engine_unit #(
	parameter int MAX_NODES = tal_pkg::MaxNodes,
	parameter int LOG_LEVELS = tal_pkg::LogLevels
) (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic start,
	input wire tal_pkg::req_t req,
	output logic busy,
	output logic done,
	output tal_pkg::rsp_t rsp,
	input wire logic cfg_valid,
	output logic cfg_ready,
	input wire logic [tal_pkg::CountW-1:0] cfg_data
);
	import tal_pkg::*;

	localparam int Levels = LOG_LEVELS + 1;
	localparam int UW = $clog2(MAX_NODES);
	localparam int HW = $clog2(Levels + 1);
	localparam int EW = UW + 1;
	localparam int AW = $clog2(MAX_NODES * Levels);
	localparam int VW = (CountW > UW + 1) ? CountW : UW + 1;
	localparam int KW = (Levels > CountW) ? Levels : CountW;
	localparam int AccW = KW + 2;

	// entry holds node+1, zero means none
	logic [EW-1:0] tbl_mem [MAX_NODES*Levels];
	logic [CountW-1:0] dep_mem [MAX_NODES];

	state_t state_q, state_d;
	req_t req_q;
	logic [CountW-1:0] count_q;
	logic [VW-1:0] live;
	logic [EW-1:0] rd_q;
	logic [CountW-1:0] dep_rd_q, du_q;
	logic [UW-1:0] u_q, v_q;
	logic [HW-1:0] h_q;
	logic [VW-1:0] bu_q;
	logic [EW-1:0] e_q, a_q;
	logic [KW-1:0] k_q;
	logic [AccW-1:0] acc_q;
	status_t st_q;
	logic [NodeW-1:0] res_q;

	logic tbl_we, tbl_re, dep_we, dep_re;
	logic [AW-1:0] tbl_addr;
	logic [EW-1:0] tbl_wdata;
	logic [UW-1:0] dep_addr;
	logic kth_mode;
	logic a_ok, b_ok, p_ok, load_ok, k_big;
	status_t start_st;
	logic [CountW-1:0] delta;
	logic delta_big;

	assign live = (VW'(count_q) > VW'(MAX_NODES)) ? VW'(MAX_NODES) : VW'(count_q);
	assign cfg_ready = (state_q == S_IDLE) && !start;
	assign busy = (state_q != S_IDLE);
	assign kth_mode = (req_q.op == OP_KTH);

	assign a_ok = VW'(req.node_a) < live;
	assign b_ok = VW'(req.node_b) < live;
	assign p_ok = VW'(req.parent_node) < live;
	assign load_ok = a_ok && (!req.has_parent || p_ok);
	assign k_big = (KW'(req.step_count) >> Levels) != '0;

	// climb amount once both depths are in
	assign delta = (du_q < dep_rd_q) ? dep_rd_q - du_q : du_q - dep_rd_q;
	assign delta_big = (KW'(delta) >> Levels) != '0;

	function automatic logic [AW-1:0] taddr(input logic [UW-1:0] u, input logic [HW-1:0] h);
		taddr = AW'(u * Levels) + AW'(h);
	endfunction

	always_ff @(posedge clk) begin
		if (tbl_we) tbl_mem[tbl_addr] <= tbl_wdata;
		if (tbl_re) rd_q <= tbl_mem[tbl_addr];
		if (dep_we) dep_mem[dep_addr] <= req.node_depth;
		if (dep_re) dep_rd_q <= dep_mem[dep_addr];
	end

	// lowest set step bit at or above h
	logic [HW-1:0] nxt_h;
	logic nxt_any;
	always_comb begin
		nxt_h = '0;
		nxt_any = 1'b0;
		for (int i = Levels - 1; i >= 0; i--) begin
			if (k_q[i] && (HW'(i) >= h_q)) begin
				nxt_h = HW'(i);
				nxt_any = 1'b1;
			end
		end
	end

	always_comb begin
		start_st = ST_OK;
		case (req.op)
			OP_LOAD: if (!load_ok) start_st = ST_RANGE;
			OP_KTH: begin
				if (!a_ok) start_st = ST_RANGE;
				else if (k_big) start_st = ST_NONE;
			end
			OP_LCA, OP_DIST: if (!(a_ok && b_ok)) start_st = ST_RANGE;
			default: ;
		endcase
	end

	logic [VW-1:0] bu_nxt;
	assign bu_nxt = bu_q + VW'(1);

	always_comb begin
		state_d = state_q;
		tbl_we = 1'b0;
		tbl_re = 1'b0;
		dep_we = 1'b0;
		dep_re = 1'b0;
		tbl_addr = taddr(u_q, h_q);
		tbl_wdata = '0;
		dep_addr = u_q;
		case (state_q)
			S_IDLE: begin
				if (start) begin
					state_d = S_DONE;
					case (req.op)
						OP_LOAD: begin
							if (load_ok) begin
								tbl_we = 1'b1;
								tbl_addr = taddr(UW'(req.node_a), '0);
								tbl_wdata = req.has_parent ? EW'(req.parent_node) + EW'(1) : '0;
								dep_we = 1'b1;
								dep_addr = UW'(req.node_a);
							end
						end
						OP_BUILD: if (live != '0) state_d = S_BLD_RD0;
						OP_KTH: if (a_ok && !k_big) state_d = S_CLB_RD;
						OP_LCA, OP_DIST: if (a_ok && b_ok) state_d = S_DEP_RD;
						default: ;
					endcase
				end
			end
			S_BLD_RD0: begin
				tbl_re = 1'b1;
				tbl_addr = taddr(bu_q[UW-1:0], h_q - HW'(1));
				state_d = S_BLD_RD1;
			end
			S_BLD_RD1: begin
				if (rd_q != '0) begin
					tbl_re = 1'b1;
					tbl_addr = taddr(UW'(rd_q - EW'(1)), h_q - HW'(1));
				end
				state_d = S_BLD_WR;
			end
			S_BLD_WR: begin
				tbl_we = 1'b1;
				tbl_addr = taddr(bu_q[UW-1:0], h_q);
				tbl_wdata = (e_q != '0) ? rd_q : '0;
				if (bu_nxt >= live) begin
					state_d = (h_q == HW'(LOG_LEVELS)) ? S_DONE : S_BLD_RD0;
				end else begin
					state_d = S_BLD_RD0;
				end
			end
			S_DEP_RD: begin
				dep_re = 1'b1;
				dep_addr = u_q;
				state_d = S_DEP_WAIT;
			end
			S_DEP_WAIT: begin
				dep_re = 1'b1;
				dep_addr = v_q;
				state_d = S_DEP_ORD;
			end
			S_DEP_ORD: state_d = delta_big ? S_DONE : S_CLB_RD;
			S_CLB_RD: begin
				if (nxt_any) begin
					tbl_re = 1'b1;
					tbl_addr = taddr(u_q, nxt_h);
					state_d = S_CLB_USE;
				end else if (kth_mode || u_q == v_q) begin
					state_d = S_DONE;
				end else begin
					state_d = S_CMP_RDA;
				end
			end
			S_CLB_USE: state_d = (rd_q == '0) ? S_DONE : S_CLB_RD;
			S_CMP_RDA: begin
				tbl_re = 1'b1;
				tbl_addr = taddr(u_q, h_q);
				state_d = S_CMP_RDB;
			end
			S_CMP_RDB: begin
				tbl_re = 1'b1;
				tbl_addr = taddr(v_q, h_q);
				state_d = S_CMP_USE;
			end
			S_CMP_USE: begin
				if (rd_q != a_q && (rd_q == '0 || a_q == '0)) state_d = S_DONE;
				else if (h_q == '0) state_d = S_FIN_RDA;
				else state_d = S_CMP_RDA;
			end
			S_FIN_RDA: begin
				tbl_re = 1'b1;
				tbl_addr = taddr(u_q, '0);
				state_d = S_FIN_RDB;
			end
			S_FIN_RDB: begin
				tbl_re = 1'b1;
				tbl_addr = taddr(v_q, '0);
				state_d = S_FIN_USE;
			end
			S_FIN_USE: state_d = S_DONE;
			S_DONE: state_d = S_IDLE;
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			count_q <= CountW'(1024);
		end else begin
			state_q <= state_d;
			if (cfg_valid && cfg_ready) count_q <= cfg_data;
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				if (start) begin
					req_q <= req;
					u_q <= UW'(req.node_a);
					v_q <= UW'(req.node_b);
					h_q <= (req.op == OP_BUILD) ? HW'(1) : '0;
					bu_q <= '0;
					k_q <= KW'(req.step_count);
					acc_q <= '0;
					res_q <= '0;
					st_q <= start_st;
				end
			end
			S_BLD_RD1: e_q <= rd_q;
			S_BLD_WR: begin
				if (bu_nxt >= live) begin
					bu_q <= '0;
					h_q <= h_q + HW'(1);
				end else begin
					bu_q <= bu_nxt;
				end
			end
			S_DEP_WAIT: du_q <= dep_rd_q;
			S_DEP_ORD: begin
				// put the deeper node in u
				if (du_q < dep_rd_q) begin
					u_q <= v_q;
					v_q <= u_q;
				end
				k_q <= KW'(delta);
				acc_q <= AccW'(delta);
				h_q <= '0;
				if (delta_big) st_q <= ST_NONE;
			end
			S_CLB_RD: begin
				if (nxt_any) h_q <= nxt_h;
				else if (kth_mode) res_q <= NodeW'(u_q);
				else if (u_q == v_q) res_q <= NodeW'(v_q);
				else h_q <= HW'(LOG_LEVELS);
			end
			S_CLB_USE: begin
				if (rd_q == '0) st_q <= ST_NONE;
				else u_q <= UW'(rd_q - EW'(1));
				h_q <= h_q + HW'(1);
			end
			S_CMP_RDB: a_q <= rd_q;
			S_CMP_USE: begin
				if (rd_q != a_q) begin
					if (rd_q == '0 || a_q == '0) st_q <= ST_NONE;
					u_q <= UW'(a_q - EW'(1));
					v_q <= UW'(rd_q - EW'(1));
					acc_q <= acc_q + (AccW'(2) << h_q);
				end
				if (h_q != '0) h_q <= h_q - HW'(1);
			end
			S_FIN_RDB: a_q <= rd_q;
			S_FIN_USE: begin
				if (a_q == '0 || a_q != rd_q) st_q <= ST_NONE;
				else res_q <= NodeW'(a_q - EW'(1));
				acc_q <= acc_q + AccW'(2);
			end
			default: ;
		endcase
	end

	logic [AccW-1:0] dsat;
	assign dsat = (acc_q > AccW'({DistW{1'b1}})) ? AccW'({DistW{1'b1}}) : acc_q;
	assign done = (state_q == S_DONE);
	always_comb begin
		rsp = '0;
		rsp.status = st_q;
		if (st_q == ST_OK) begin
			if (req_q.op inside {OP_KTH, OP_LCA}) rsp.result_node = res_q;
			if (req_q.op == OP_DIST) rsp.distance = DistW'(dsat);
		end
	end

	ast_done_one: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done) else $error("done held for two cycles");
	ast_no_cfg_busy: assert property (@(posedge clk) disable iff (!arst_n)
		busy |-> !cfg_ready) else $error("config ready while busy");
	ast_start_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> busy) else $error("request not taken");
endmodule
`default_nettype wire

// ----- bench/tree_ancestor_lca_engine_unit_tb.sv -----
// Testbench for the binary lifting ancestor engine: random trees, queries, self-checking.
`default_nettype none
module tree_ancestor_lca_engine_unit_tb;
	import tal_pkg::*;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int IdleLimit = 200000;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic start = 1'b0;
	req_t req = '0;
	logic busy, done;
	rsp_t rsp;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [CountW-1:0] cfg_data = '0;

	tree_ancestor_lca_engine_unit uut (
		.clk(clk), .arst_n(arst_n), .start(start), .req(req), .busy(busy), .done(done),
		.rsp(rsp), .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// shadow copy of the engine state
	logic [CountW-1:0] anc_tab [MaxNodes][LogLevels+1];
	logic [CountW-1:0] depth_mem [MaxNodes];
	int unsigned node_cnt = 1024;

	req_t pending_reqs[$];
	rsp_t expected_rsps[$];
	bit took = 1'b0;
	int accepted = 0;
	int send_idle = 25;
	int errors = 0;
	int idle_cycles = 0;

	// generator view of the loaded tree
	int gen_depth [MaxNodes];
	int gen_live = 1024;

	function automatic logic [CountW-1:0] tab(int unsigned u, int unsigned h);
		if (u >= MaxNodes || h > LogLevels) return '0;
		return anc_tab[u][h];
	endfunction

	function automatic bit lift(inout int unsigned x, input int unsigned k);
		int unsigned y;
		logic [CountW-1:0] e;
		y = x;
		if ((k >> (LogLevels + 1)) != 0) return 1'b0;
		for (int h = 0; h <= LogLevels; h++) begin
			if (k[h]) begin
				e = tab(y, h);
				if (e == 0) return 1'b0;
				y = e - 1;
			end
		end
		x = y;
		return 1'b1;
	endfunction

	function automatic bit join_nodes(int unsigned u, int unsigned v,
			output int unsigned lca, output int unsigned span);
		int unsigned du, dv, t, delta, acc;
		logic [CountW-1:0] a, b;
		lca = 0;
		span = 0;
		du = depth_mem[u];
		dv = depth_mem[v];
		if (du < dv) begin
			t = u; u = v; v = t;
			t = du; du = dv; dv = t;
		end
		delta = du - dv;
		if (!lift(u, delta)) return 1'b0;
		if (u == v) begin
			lca = v;
			span = delta;
			return 1'b1;
		end
		acc = delta;
		for (int h = LogLevels; h >= 0; h--) begin
			a = tab(u, h);
			b = tab(v, h);
			if (a != b) begin
				if (a == 0 || b == 0) return 1'b0;
				u = a - 1;
				v = b - 1;
				acc += 2 << h;
			end
		end
		a = tab(u, 0);
		b = tab(v, 0);
		if (a == 0 || a != b) return 1'b0;
		lca = a - 1;
		acc += 2;
		span = acc > 2047 ? 2047 : acc;
		return 1'b1;
	endfunction

	function automatic rsp_t predict_rsp(req_t r);
		rsp_t o;
		int unsigned live, x, l, d;
		logic [CountW-1:0] e;
		o = '0;
		live = node_cnt < MaxNodes ? node_cnt : MaxNodes;
		case (r.op)
			OP_LOAD: begin
				if (r.node_a >= live || (r.has_parent && r.parent_node >= live)) begin
					o.status = ST_RANGE;
				end else begin
					anc_tab[r.node_a][0] = r.has_parent ? CountW'(r.parent_node + 1) : '0;
					depth_mem[r.node_a] = r.node_depth;
				end
			end
			OP_BUILD: begin
				for (int h = 1; h <= LogLevels; h++)
					for (int u = 0; u < live; u++) begin
						e = tab(u, h - 1);
						anc_tab[u][h] = e != 0 ? tab(e - 1, h - 1) : '0;
					end
			end
			OP_KTH: begin
				if (r.node_a >= live) begin
					o.status = ST_RANGE;
				end else begin
					x = r.node_a;
					if (lift(x, r.step_count)) o.result_node = NodeW'(x);
					else o.status = ST_NONE;
				end
			end
			OP_LCA, OP_DIST: begin
				if (r.node_a >= live || r.node_b >= live) begin
					o.status = ST_RANGE;
				end else if (!join_nodes(r.node_a, r.node_b, l, d)) begin
					o.status = ST_NONE;
				end else if (r.op == OP_LCA) begin
					o.result_node = NodeW'(l);
				end else begin
					o.distance = DistW'(d);
				end
			end
			default: ;
		endcase
		return o;
	endfunction

	// driver: hold start until taken, then advance or idle
	always @(negedge clk) begin
		if (arst_n && (!start || took)) begin
			if (pending_reqs.size() != 0 && $urandom_range(99) >= send_idle) begin
				req <= pending_reqs.pop_front();
				start <= 1'b1;
			end else begin
				start <= 1'b0;
			end
		end
	end

	// monitor: check responses, predict on accepted requests
	always @(posedge clk) begin
		rsp_t want;
		bit active;
		active = 1'b0;
		took = 1'b0;
		if (arst_n) begin
			if (done) begin
				active = 1'b1;
				if (expected_rsps.size() == 0) begin
					errors++;
					if (errors <= 10) $display("unexpected response %h", rsp);
				end else begin
					want = expected_rsps.pop_front();
					if (rsp.result_node !== want.result_node || rsp.distance !== want.distance
							|| rsp.status !== want.status) begin
						errors++;
						if (errors <= 10)
							$display("mismatch: exp node %0d dist %0d st %0d, got node %0d dist %0d st %0d",
								want.result_node, want.distance, want.status,
								rsp.result_node, rsp.distance, rsp.status);
					end
				end
			end
			if (start && !busy) begin
				active = 1'b1;
				took = 1'b1;
				accepted++;
				send_idle = accepted < 600 ? 25 : (accepted < 1200 ? 57 : 0);
				expected_rsps.push_back(predict_rsp(req));
			end
			if (cfg_valid && cfg_ready) active = 1'b1;
		end
		idle_cycles = active ? 0 : idle_cycles + 1;
		if (idle_cycles >= IdleLimit) begin
			$display("Testbench completed WITH ERRORS");
			$finish;
		end
	end

	task automatic drain();
		while (pending_reqs.size() != 0 || start || expected_rsps.size() != 0) @(posedge clk);
		repeat (3) @(posedge clk);
	endtask

	task automatic write_count(int unsigned v);
		drain();
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_data <= CountW'(v);
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		node_cnt = v;
		gen_live = v < MaxNodes ? v : MaxNodes;
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	function automatic req_t rand_req(logic [2:0] op);
		req_t r;
		r = $bits(req_t)'({$urandom, $urandom});
		r.op = op;
		return r;
	endfunction

	function automatic logic [NodeW-1:0] pick_node();
		if (gen_live == 0 || $urandom_range(19) == 0) return NodeW'($urandom_range(1023));
		return NodeW'($urandom_range(gen_live - 1));
	endfunction

	// load a random forest over all live nodes, then build; chain_pct sets depth
	task automatic load_tree(int chain_pct);
		req_t r;
		int p;
		for (int i = 0; i < gen_live; i++) begin
			r = rand_req(OP_LOAD);
			r.node_a = NodeW'(i);
			if (i == 0 || $urandom_range(39) == 0) begin
				r.has_parent = 1'b0;
				gen_depth[i] = 1;
			end else begin
				p = $urandom_range(99) < chain_pct ? i - 1 : $urandom_range(i - 1);
				r.has_parent = 1'b1;
				r.parent_node = NodeW'(p);
				gen_depth[i] = gen_depth[p] + 1;
			end
			r.node_depth = CountW'(gen_depth[i]);
			pending_reqs.push_back(r);
		end
		drain();
		pending_reqs.push_back(rand_req(OP_BUILD));
	endtask

	task automatic random_mix(int n);
		req_t r;
		int sel, p;
		for (int i = 0; i < n; i++) begin
			sel = $urandom_range(99);
			if (sel < 40) begin
				r = rand_req(OP_KTH);
				r.node_a = pick_node();
				if ($urandom_range(3) != 0 && r.node_a < gen_live)
					r.step_count = NodeW'($urandom_range(gen_depth[r.node_a]));
			end else if (sel < 88) begin
				r = rand_req(sel < 64 ? OP_LCA : OP_DIST);
				r.node_a = pick_node();
				r.node_b = pick_node();
			end else if (sel < 93 && gen_live > 1) begin
				// re-parent a node consistently with its new parent
				r = rand_req(OP_LOAD);
				r.node_a = NodeW'($urandom_range(gen_live - 1, 1));
				p = $urandom_range(r.node_a - 1);
				r.has_parent = 1'b1;
				r.parent_node = NodeW'(p);
				gen_depth[r.node_a] = gen_depth[p] + 1;
				r.node_depth = CountW'(gen_depth[r.node_a]);
			end else if (sel < 96) begin
				r = rand_req(OP_LOAD);
			end else if (sel < 98) begin
				r = rand_req(OP_BUILD);
			end else begin
				r = rand_req(3'($urandom_range(7, 5)));
			end
			pending_reqs.push_back(r);
		end
	endtask

	initial begin
		req_t r;
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// no valid nodes: every request that names a node is out of range
		write_count(0);
		for (int op = 0; op < 8; op++) pending_reqs.push_back(rand_req(3'(op)));
		r = rand_req(OP_LOAD);
		r.node_a = 0;
		r.has_parent = 1'b0;
		pending_reqs.push_back(r);

		// single root
		write_count(1);
		r = rand_req(OP_LOAD);
		r.node_a = 0;
		r.has_parent = 1'b1;
		r.parent_node = 1;
		pending_reqs.push_back(r);
		r.node_a = 1;
		r.has_parent = 1'b0;
		pending_reqs.push_back(r);
		load_tree(0);
		for (int k = 0; k < 3; k++) begin
			r = rand_req(OP_KTH);
			r.node_a = 0;
			r.step_count = NodeW'(k == 2 ? 1023 : k);
			pending_reqs.push_back(r);
		end
		r = rand_req(OP_LCA);
		r.node_a = 0;
		r.node_b = 0;
		pending_reqs.push_back(r);
		r.op = OP_DIST;
		pending_reqs.push_back(r);
		r.node_b = 1;
		pending_reqs.push_back(r);

		// oversized count: full 1024-node deep tree
		write_count(2047);
		load_tree(90);
		r = rand_req(OP_KTH);
		r.node_a = 1023;
		r.step_count = NodeW'(gen_depth[1023] - 1);
		pending_reqs.push_back(r);
		r = rand_req(OP_DIST);
		r.node_a = 1023;
		r.node_b = 0;
		pending_reqs.push_back(r);
		random_mix(250);

		write_count(1024);
		random_mix(150);

		write_count($urandom_range(60, 5));
		load_tree(40);
		random_mix(90);
		write_count($urandom_range(200, 2));
		load_tree(20);
		random_mix(80);

		drain();
		repeat (20) @(posedge clk);
		if (expected_rsps.size() != 0) errors++;
		if (errors == 0) begin
			$display("Testbench completed without errors");
		end else begin
			$display("Testbench completed WITH ERRORS");
		end
		$finish;
	end
endmodule
`default_nettype wire

// ----- filelist.f -----
sv/tal_pkg.sv
sv/tree_ancestor_lca_engine_unit.sv
bench/tree_ancestor_lca_engine_unit_tb.sv
